/* design/scgg_pkg.sv */
// shared types and constants for the sticker colour grouping block
// no dependencies
package scgg_pkg;
    localparam int COORD_W = 18;
    localparam logic [15:0] COEF_C = 16'd23180;
    localparam logic [15:0] COEF_S = 16'd23161;
    typedef logic signed [COORD_W-1:0] coord_t;
endpackage

/* design/sticker_color_greedy_grouping.sv */
// top level of the sticker colour grouping block
// depends on scgg_pkg
// An item is taken only in the idle state. Each colour is then projected over
// a short multiply sequence and written to the coordinate memory, so a new
// item is not accepted until the previous one has been written. After the
// last item the grouping sequencer scans the memory once per pick, through one
// read port. A sticker that is already taken is skipped without a read. Any
// other sticker passes through the scan step, the read, the difference, two
// squares, a bit-serial square root and the compare. A cube needs 48 picks,
// and the result side can stall them. No item is taken while a projection
// or the grouping runs.
module sticker_color_greedy_grouping #(
    parameter int NUM_FACES      = 6,
    parameter int CELLS_PER_FACE = 9
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // face[2:0], cell_res[6:3], group[9:7], zero
    output logic        m_tlast    // last_result
);
    import scgg_pkg::*;

    localparam int TOTAL = NUM_FACES * CELLS_PER_FACE;
    localparam int IW    = $clog2(TOTAL + 1);
    localparam int FW    = $clog2(NUM_FACES);
    localparam int CW    = $clog2(CELLS_PER_FACE);
    localparam int CENTRE = CELLS_PER_FACE / 2;

    function automatic logic [TOTAL-1:0] centre_mask();
        logic [TOTAL-1:0] m;
        m = '0;
        for (int f = 0; f < NUM_FACES; f++)
            m[f*CELLS_PER_FACE+CENTRE] = 1'b1;
        return m;
    endfunction

    typedef enum logic [4:0] {
        S_IDLE, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_WR,
        S_SEED, S_SRD, S_SEMIT, S_RD, S_DX, S_SQ1, S_SQ2, S_SQRT, S_CMP,
        S_EMIT, S_NEXT
    } state_t;

    state_t state_reg;
    coord_t first_mem [TOTAL];
    coord_t third_mem [TOTAL];
    coord_t rd_first_reg, rd_third_reg, seed_first_reg, seed_third_reg;
    logic [TOTAL-1:0] taken_reg;
    logic [IW-1:0] load_reg, idx_reg, best_reg, seed_idx_reg;
    logic [FW-1:0] grp_reg;
    logic [CW:0] cnt_reg;
    logic [7:0] r_reg, g_reg, b_reg;
    logic signed [47:0] acc_reg, prod_reg, u_reg;
    logic [37:0] d2_reg, sq_reg, op_reg;
    logic [19:0] res_reg;
    logic [37:0] one_reg;
    logic [19:0] best_d_reg;
    logic found_reg;
    logic signed [COORD_W:0] dx_reg, dz_reg;
    logic m_valid_reg, m_last_reg;
    logic [FW-1:0] out_grp_reg;
    logic [FW-1:0] scan_face_reg, best_face_reg, out_face_reg, scan_face_next;
    logic [CW-1:0] scan_cell_reg, best_cell_reg, out_cell_reg, scan_cell_next;
    logic rd_en;
    logic [IW-1:0] rd_addr;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    always_comb begin
        m_tdata = '0;
        m_tdata[2:0] = 3'(out_face_reg);
        m_tdata[6:3] = 4'(out_cell_reg);
        m_tdata[9:7] = 3'(out_grp_reg);
    end

    // face and cell of the scan position, stepped alongside idx_reg
    always_comb begin
        if (scan_cell_reg == CW'(CELLS_PER_FACE - 1)) begin
            scan_cell_next = '0;
            scan_face_next = scan_face_reg + 1'b1;
        end else begin
            scan_cell_next = scan_cell_reg + 1'b1;
            scan_face_next = scan_face_reg;
        end
    end

    // single read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_first_reg <= first_mem[rd_addr];
            rd_third_reg <= third_mem[rd_addr];
        end
    end
    assign rd_en   = (state_reg == S_SRD) || (state_reg == S_RD);
    assign rd_addr = (state_reg == S_SRD) ? seed_idx_reg : idx_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == S_WR) begin
            first_mem[load_reg] <= coord_t'(acc_reg >>> 0);
            third_mem[load_reg] <= coord_t'(prod_reg);
        end
    end

    logic [37:0] trial;
    assign trial = 38'(res_reg) + one_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            load_reg    <= '0;
            taken_reg   <= '0;
            m_valid_reg <= 1'b0;
            m_last_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (s_tvalid) begin
                    r_reg <= s_tdata[7:0];
                    g_reg <= s_tdata[15:8];
                    b_reg <= s_tdata[23:16];
                    state_reg <= S_P1;
                end
                S_P1: begin
                    acc_reg  <= 48'(r_reg * COEF_C);
                    prod_reg <= 48'(g_reg * COEF_S);
                    state_reg <= S_P2;
                end
                S_P2: begin
                    // first coordinate, rounded Q.15 -> Q.8
                    acc_reg  <= (acc_reg - prod_reg + 48'sd64) >>> 7;
                    u_reg    <= 48'(r_reg * COEF_S);
                    prod_reg <= 48'(g_reg * COEF_C);
                    state_reg <= S_P3;
                end
                S_P3: begin
                    u_reg <= u_reg + prod_reg;
                    state_reg <= S_P4;
                end
                S_P4: begin
                    // u stays below 2^24
                    u_reg <= $signed(u_reg[24:0]) * $signed({1'b0, COEF_S});
                    prod_reg <= 48'(b_reg * COEF_C);
                    state_reg <= S_P5;
                end
                S_P5: begin
                    prod_reg <= (prod_reg <<< 15) - u_reg;
                    state_reg <= S_P6;
                end
                S_P6: begin
                    prod_reg <= (prod_reg + 48'sd2097152) >>> 22;
                    state_reg <= S_WR;
                end
                S_P7: state_reg <= S_WR;
                S_WR: begin
                    if (load_reg == IW'(TOTAL - 1)) begin
                        load_reg <= '0;
                        taken_reg <= centre_mask();
                        grp_reg <= '0;
                        seed_idx_reg <= IW'(CENTRE);
                        state_reg <= S_SRD;
                    end else begin
                        load_reg <= load_reg + 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_SRD: state_reg <= S_SEED;
                S_SEED: begin
                    seed_first_reg <= rd_first_reg;
                    seed_third_reg <= rd_third_reg;
                    state_reg <= S_SEMIT;
                end
                S_SEMIT: if (!m_valid_reg) begin
                    out_face_reg <= grp_reg;
                    out_cell_reg <= CW'(CENTRE);
                    out_grp_reg <= grp_reg;
                    m_valid_reg <= 1'b1;
                    m_last_reg  <= 1'b0;
                    cnt_reg <= (CW+1)'(1);
                    idx_reg <= '0;
                    scan_face_reg <= '0;
                    scan_cell_reg <= '0;
                    found_reg <= 1'b0;
                    state_reg <= S_NEXT;
                end
                S_NEXT: begin
                    if (cnt_reg == (CW+1)'(CELLS_PER_FACE)) begin
                        if (grp_reg == FW'(NUM_FACES - 1)) state_reg <= S_IDLE;
                        else begin
                            grp_reg <= grp_reg + 1'b1;
                            seed_idx_reg <= seed_idx_reg + IW'(CELLS_PER_FACE);
                            state_reg <= S_SRD;
                        end
                    end else if (idx_reg == IW'(TOTAL)) begin
                        state_reg <= found_reg ? S_EMIT : S_IDLE;
                    end else if (taken_reg[idx_reg[IW-1:0]]) begin
                        idx_reg <= idx_reg + 1'b1;
                        scan_face_reg <= scan_face_next;
                        scan_cell_reg <= scan_cell_next;
                    end else begin
                        state_reg <= S_RD;
                    end
                end
                S_RD: state_reg <= S_DX;
                S_DX: begin
                    dx_reg <= (COORD_W+1)'(seed_first_reg) - (COORD_W+1)'(rd_first_reg);
                    dz_reg <= (COORD_W+1)'(seed_third_reg) - (COORD_W+1)'(rd_third_reg);
                    state_reg <= S_SQ1;
                end
                S_SQ1: begin
                    d2_reg <= 38'(dx_reg * dx_reg);
                    state_reg <= S_SQ2;
                end
                S_SQ2: begin
                    sq_reg <= 38'(dz_reg * dz_reg);
                    state_reg <= S_SQRT;
                    res_reg <= '0;
                    one_reg <= 38'(1) << 20;
                    // operand computed next cycle
                    op_reg <= 38'(0);
                end
                S_SQRT: begin
                    // one result bit a cycle
                    if (one_reg == 38'(1) << 20) begin
                        op_reg <= (d2_reg + sq_reg) >> 16;
                        one_reg <= 38'(1) << 18;
                    end else if (one_reg == '0) begin
                        state_reg <= S_CMP;
                    end else begin
                        if (op_reg >= trial) begin
                            op_reg  <= op_reg - trial;
                            res_reg <= 20'((38'(res_reg) >> 1) + one_reg);
                        end else begin
                            res_reg <= res_reg >> 1;
                        end
                        one_reg <= one_reg >> 2;
                    end
                end
                S_CMP: begin
                    if (!found_reg || res_reg <= best_d_reg) begin
                        found_reg <= 1'b1;
                        best_d_reg <= res_reg;
                        best_reg <= idx_reg;
                        best_face_reg <= scan_face_reg;
                        best_cell_reg <= scan_cell_reg;
                    end
                    idx_reg <= idx_reg + 1'b1;
                    scan_face_reg <= scan_face_next;
                    scan_cell_reg <= scan_cell_next;
                    state_reg <= S_NEXT;
                end
                S_EMIT: if (!m_valid_reg) begin
                    taken_reg[best_reg] <= 1'b1;
                    out_face_reg <= best_face_reg;
                    out_cell_reg <= best_cell_reg;
                    out_grp_reg <= grp_reg;
                    m_valid_reg <= 1'b1;
                    m_last_reg  <= (grp_reg == FW'(NUM_FACES - 1)) &&
                                   (cnt_reg == (CW+1)'(CELLS_PER_FACE - 1));
                    cnt_reg <= cnt_reg + 1'b1;
                    idx_reg <= '0;
                    scan_face_reg <= '0;
                    scan_cell_reg <= '0;
                    found_reg <= 1'b0;
                    state_reg <= S_NEXT;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

/* test/tb.sv */
// self-checking bench for sticker_color_greedy_grouping: loads whole cubes, predicts the
// projected coordinates and the greedy colour grouping, and compares every assignment
// depends on scgg_pkg and the design files
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import scgg_pkg::*;

    localparam int FACES = 6;
    localparam int CELLS = 9;
    localparam int STICKERS = FACES * CELLS;
    localparam int CENTRE = CELLS / 2;
    localparam int NUM_CUBES = 8;
    localparam int LONG_HOLD = 600;

    typedef struct packed {
        logic [2:0] face;
        logic [3:0] cell_no;
        logic [2:0] grp;
        logic       last;
    } assignment_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // red[7:0], green[15:8], blue[23:16]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // face[2:0], cell_res[6:3], group[9:7], zero
    logic        m_tlast;        // last_result

    sticker_color_greedy_grouping DUT (.*);

    logic [23:0]  colour_queue[$];
    assignment_t  assignment_queue[$];
    longint       coord_x[STICKERS];
    longint       coord_z[STICKERS];
    int           stickers_loaded = 0;
    int           items_sent = 0;
    int           results_seen = 0;
    int           cubes_done = 0;
    int           errors = 0;
    bit           item_taken = 1'b0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #12ms;
        $display("timeout after %0d items and %0d results", items_sent, results_seen);
        $display("TEST FAILED");
        $finish;
    end

    task automatic report(input string what);
        errors++;
        $display("%t mismatch: %s", $realtime, what);
    endtask

    function automatic longint int_sqrt(input longint x);
        longint res;
        res = 0;
        for (int b = 31; b >= 0; b--) begin
            if ((res | (64'd1 << b)) * (res | (64'd1 << b)) <= x) res |= (64'd1 << b);
        end
        return res;
    endfunction

    function automatic longint seed_distance(input int a, input int b);
        longint dx, dz;
        dx = coord_x[a] - coord_x[b];
        dz = coord_z[a] - coord_z[b];
        return int_sqrt((dx * dx + dz * dz) >>> 16);
    endfunction

    // greedy fill, group by group, ties to the higher position
    task automatic group_stickers();
        bit          taken[STICKERS];
        int          seed, best;
        longint      best_d, d;
        bit          found;
        assignment_t a;
        for (int i = 0; i < STICKERS; i++) taken[i] = (i % CELLS) == CENTRE;
        for (int g = 0; g < FACES; g++) begin
            seed = g * CELLS + CENTRE;
            a = '{face: 3'(g), cell_no: 4'(CENTRE), grp: 3'(g), last: 1'b0};
            assignment_queue = {assignment_queue, a};
            for (int k = 1; k < CELLS; k++) begin
                found = 0;
                best = 0;
                best_d = 0;
                for (int i = 0; i < STICKERS; i++) begin
                    if (!taken[i]) begin
                        d = seed_distance(seed, i);
                        if (!found || d <= best_d) begin
                            found = 1;
                            best = i;
                            best_d = d;
                        end
                    end
                end
                taken[best] = 1;
                a = '{face: 3'(best / CELLS), cell_no: 4'(best % CELLS), grp: 3'(g),
                      last: 1'b0};
                assignment_queue = {assignment_queue, a};
            end
        end
        assignment_queue[$].last = 1'b1;
    endtask

    task automatic load_sticker(input logic [23:0] rgb);
        longint r, g, b, u, cc, cs;
        cc = longint'(COEF_C);
        cs = longint'(COEF_S);
        r = rgb[7:0];
        g = rgb[15:8];
        b = rgb[23:16];
        u = r * cs + g * cc;
        coord_x[stickers_loaded] = (r * cc - g * cs + 64) >>> 7;
        coord_z[stickers_loaded] = (b * cc * 32768 - u * cs + (64'sd1 << 21)) >>> 22;
        stickers_loaded++;
        if (stickers_loaded == STICKERS) begin
            group_stickers();
            stickers_loaded = 0;
        end
    endtask

    function automatic logic [7:0] jitter(input logic [7:0] base, input int spread);
        int v;
        v = int'(base) + $urandom_range(2 * spread) - spread;
        return v < 0 ? 8'd0 : (v > 255 ? 8'd255 : v[7:0]);
    endfunction

    // kinds: 0 extremes then random, 1 six clusters shuffled, 2 full random,
    // 3 few distinct colours so distances tie often
    task automatic add_cube(input int kind);
        logic [23:0] palette[6];
        logic [23:0] c;
        int          spread;
        for (int p = 0; p < 6; p++) palette[p] = 24'($urandom);
        spread = $urandom_range(30);
        for (int i = 0; i < STICKERS; i++) begin
            case (kind)
                0: begin
                    if (i < 8) c = {{8{i[2]}}, {8{i[1]}}, {8{i[0]}}};
                    else if (i < 14) c = {3{8'h01 << (i - 8)}};
                    else if (i < 18) c = {8'h7f, 8'h80, 8'hff} >> (i - 14);
                    else c = 24'($urandom);
                end
                1: begin
                    c = palette[$urandom_range(5)];
                    c = {jitter(c[23:16], spread), jitter(c[15:8], spread), jitter(c[7:0], spread)};
                end
                2: c = 24'($urandom);
                default: c = palette[$urandom_range(1)];
            endcase
            colour_queue = {colour_queue, c};
        end
    endtask

    // input side: bursts and gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge aclk) begin
        if (aresetn) begin
            if (item_taken) begin
                void'(colour_queue.pop_front());
                item_taken = 1'b0;
                burst_left--;
                s_tvalid = 1'b0;
            end
            // an item on offer is held until it is taken
            if (!s_tvalid) begin
                if (burst_left <= 0) begin
                    if (gap_left > 0) begin
                        gap_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
                if (burst_left > 0 && colour_queue.size() > 0) begin
                    s_tvalid = 1'b1;
                    s_tdata = colour_queue[0];
                end
            end
            if (!s_tvalid) s_tdata = 24'($urandom);
        end
    end

    // result side: own stall pattern, plus one long hold-off
    int hold_left = 0;
    int stall_mode = 0;
    bit long_hold_done = 1'b0;

    always @(negedge aclk) begin
        if (aresetn) begin
            if (!long_hold_done && cubes_done == 1 && m_tvalid) begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if ($urandom_range(63) == 0) stall_mode = $urandom_range(3);
            if (hold_left > 0) begin
                hold_left--;
                m_tready = 1'b0;
            end else begin
                case (stall_mode)
                    0: m_tready = 1'b1;
                    1: m_tready = $urandom_range(1);
                    2: m_tready = $urandom_range(4) != 0;
                    default: m_tready = $urandom_range(5) == 0;
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                load_sticker(s_tdata);
                items_sent++;
                item_taken = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (assignment_queue.size() == 0) begin
                    report($sformatf("unexpected result %h", m_tdata));
                end else begin
                    assignment_t e;
                    e = assignment_queue.pop_front();
                    if (m_tdata !== {6'd0, e.grp, e.cell_no, e.face} || m_tlast !== e.last)
                        report($sformatf("got data %h last %b, want face %0d cell %0d group %0d last %b",
                                         m_tdata, m_tlast, e.face, e.cell_no, e.grp, e.last));
                    if (e.last) cubes_done++;
                end
            end
        end
    end

    initial begin
        add_cube(0);
        for (int n = 1; n < NUM_CUBES; n++) add_cube(n % 2 == 1 ? 1 : ((n % 4 == 2) ? 2 : 3));
        repeat (11) @(posedge aclk);
        @(negedge aclk) aresetn = 1'b1;
        while (colour_queue.size() > 0 || assignment_queue.size() > 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        $display("%0d cubes loaded (%0d colours), %0d assignments checked", cubes_done,
                 items_sent, results_seen);
        $display("covered extremes, clustered, random and heavily tied cubes with stalls");
        if (errors == 0 && assignment_queue.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
